// ----- sv/keyword_substitution_cipher_unit_defines.svh -----
// Assertion macros used by the checker file.
`ifndef KEYWORD_SUBSTITUTION_CIPHER_UNIT_DEFINES_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_UNIT_DEFINES_SVH

// Clocked assertion, quiet while reset is asserted.
`define KSCU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define KSCU_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/kscu_pkg.sv -----
package kscu_pkg;

  localparam int unsigned LETTERS = 26;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned OP_W    = 3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LETTERS - 1);
  localparam logic [IDX_W-1:0] FULL_LEN = IDX_W'(LETTERS);
  localparam logic [LETTERS-1:0] ALL_USED = '1;

  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UZ = 8'h5A;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LZ = 8'h7A;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
  localparam logic [OP_W-1:0] OP_KEY     = 3'd1;
  localparam logic [OP_W-1:0] OP_FINISH  = 3'd2;
  localparam logic [OP_W-1:0] OP_ENCRYPT = 3'd3;
  localparam logic [OP_W-1:0] OP_DECRYPT = 3'd4;

  typedef struct packed {
    logic             is_letter;
    logic [IDX_W-1:0] idx;
  } letter_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             clear;
    logic             key_byte;
    logic             walk;
    logic [IDX_W-1:0] walk_idx;
    logic             done;
    logic             text;
  } cmd_t;

  // Letter index of an ASCII letter of either case
  function automatic letter_t letter_of(input logic [7:0] b);
    letter_t r;
    logic [7:0] d;
    r = '0;
    d = '0;
    if (b >= CHAR_UA && b <= CHAR_UZ) begin
      d = b - CHAR_UA;
      r.is_letter = 1'b1;
    end else if (b >= CHAR_LA && b <= CHAR_LZ) begin
      d = b - CHAR_LA;
      r.is_letter = 1'b1;
    end
    r.idx = d[IDX_W-1:0];
    return r;
  endfunction

endpackage

// ----- sv/kscu_ctrl.sv -----
module kscu_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [kscu_pkg::OP_W-1:0] in_op,
  output logic                      in_stall,
  input  logic                      out_valid,
  input  logic                      out_stall,
  output kscu_pkg::cmd_t            cmd
);
  import kscu_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_FINISH = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] walk_r, walk_nxt;
  logic             accept;

  // Hold input while finishing or while the result slot is blocked
  assign in_stall = (state_r != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    walk_nxt  = walk_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_CLEAR: cmd.clear = 1'b1;
            OP_KEY:   cmd.key_byte = 1'b1;
            OP_FINISH: begin
              state_nxt = S_FINISH;
              walk_nxt  = '0;
            end
            OP_ENCRYPT, OP_DECRYPT: cmd.text = 1'b1;
            default: ;
          endcase
        end
      end
      S_FINISH: begin
        // Walk the alphabet, appending each unused letter
        cmd.walk     = 1'b1;
        cmd.walk_idx = walk_r;
        if (walk_r == LAST_IDX) begin
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          walk_nxt = walk_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      walk_r  <= '0;
    end else begin
      state_r <= state_nxt;
      walk_r  <= walk_nxt;
    end
  end

endmodule

// ----- sv/kscu_dpath.sv -----
module kscu_dpath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kscu_pkg::cmd_t            cmd,
  input  logic [kscu_pkg::OP_W-1:0] in_op,
  input  logic [7:0]                in_byte_in,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic [7:0]                out_byte_out,
  output logic                      out_status
);
  import kscu_pkg::*;

  logic [IDX_W-1:0]   fwd_r [LETTERS];
  logic [IDX_W-1:0]   fwd_nxt [LETTERS];
  logic [IDX_W-1:0]   inv_r [LETTERS];
  logic [IDX_W-1:0]   inv_nxt [LETTERS];
  logic [LETTERS-1:0] used_r, used_nxt;
  logic [IDX_W-1:0]   len_r, len_nxt;
  logic               ready_r, ready_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic               out_status_r, out_status_nxt;

  letter_t          in_li;
  logic             app_req;
  logic             app_en;
  logic [IDX_W-1:0] app_idx;
  logic [IDX_W-1:0] look;

  assign in_li   = letter_of(in_byte_in);
  assign app_idx = cmd.walk ? cmd.walk_idx : in_li.idx;
  assign app_req = cmd.walk || (cmd.key_byte && in_li.is_letter);
  assign app_en  = app_req && !used_r[app_idx] && (len_r < FULL_LEN);

  // Key state: append letters, keeping the inverse table in step
  always_comb begin
    fwd_nxt   = fwd_r;
    inv_nxt   = inv_r;
    used_nxt  = used_r;
    len_nxt   = len_r;
    ready_nxt = ready_r;
    if (cmd.clear) begin
      used_nxt  = '0;
      len_nxt   = '0;
      ready_nxt = 1'b0;
    end
    if (app_en) begin
      fwd_nxt[len_r]    = app_idx;
      inv_nxt[app_idx]  = len_r;
      used_nxt[app_idx] = 1'b1;
      len_nxt           = len_r + 1'b1;
    end
    if (cmd.done) begin
      used_nxt  = ALL_USED;
      len_nxt   = FULL_LEN;
      ready_nxt = 1'b1;
    end
  end

  // Result word: table lookup for letters, pass-through otherwise
  always_comb begin
    look           = (in_op == OP_ENCRYPT) ? fwd_r[in_li.idx] : inv_r[in_li.idx];
    out_valid_nxt  = out_valid_r && out_stall;
    out_byte_nxt   = out_byte_r;
    out_status_nxt = out_status_r;
    if (cmd.text) begin
      out_valid_nxt = 1'b1;
      if (!ready_r) begin
        out_byte_nxt   = in_byte_in;
        out_status_nxt = 1'b1;
      end else begin
        out_byte_nxt   = in_li.is_letter ? (CHAR_UA + {3'b000, look}) : in_byte_in;
        out_status_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LETTERS; i++) begin
        fwd_r[i] <= IDX_W'(i);
        inv_r[i] <= IDX_W'(i);
      end
      used_r      <= ALL_USED;
      len_r       <= FULL_LEN;
      ready_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      fwd_r       <= fwd_nxt;
      inv_r       <= inv_nxt;
      used_r      <= used_nxt;
      len_r       <= len_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r   <= out_byte_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_byte_out = out_byte_r;
  assign out_status   = out_status_r;

endmodule

// ----- sv/keyword_substitution_cipher_unit.sv -----
// Keyword substitution cipher.
// Input channel (in_valid / in_stall, in_op, in_byte_in) takes one word per op:
// clear key, keyword byte, finish key, encrypt byte or decrypt byte.
// Output channel (out_valid / out_stall, out_byte_out, out_status) returns one
// word for each encrypt or decrypt; other ops return nothing.
// A text byte appears on the output in the cycle after it is accepted.
// Throughput: clear, keyword, encrypt and decrypt do not hold off input, so text
// streams at one byte per cycle while the result word is not blocked. For finish,
// the controller walks all 26 letters through the append path, one letter per
// cycle, with input held. The result register holds a word while out_stall is
// high; further input is also held off while that word is blocked.
// Encrypt or decrypt after clear and before finish returns the byte unchanged with status 1.
// Reset loads the identity key, marks it ready and empties the result register.
module keyword_substitution_cipher_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [kscu_pkg::OP_W-1:0] in_op,
  input  logic [7:0]                in_byte_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_byte_out,
  output logic                      out_status
);
  import kscu_pkg::*;

  cmd_t cmd;

  kscu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  kscu_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_op        (in_op),
    .in_byte_in   (in_byte_in),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_byte_out (out_byte_out),
    .out_status   (out_status)
  );

endmodule

// ----- sv/kscu_checker.sv -----
`include "keyword_substitution_cipher_unit_defines.svh"

module kscu_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [kscu_pkg::OP_W-1:0] in_op,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [7:0]                out_byte_out,
  input logic                      out_status
);
  import kscu_pkg::*;

  logic       accept;
  logic       is_text;
  logic       is_finish;
  logic       text_in;
  logic       blocked;
  logic [8:0] out_word;

  assign accept    = in_valid && !in_stall;
  assign is_text   = (in_op == OP_ENCRYPT) || (in_op == OP_DECRYPT);
  assign is_finish = (in_op == OP_FINISH);
  assign text_in   = accept && is_text;
  assign blocked   = out_valid && out_stall;
  assign out_word  = {out_byte_out, out_status};

  // Blocked result word holds
  `KSCU_ASSERT(a_out_hold, blocked |=> out_valid && $stable(out_word), "stalled word changed")
  // Text word yields a result next cycle
  `KSCU_ASSERT(a_text_result, text_in |=> out_valid, "text word gave no result")
  // Non-text word yields no new result
  `KSCU_ASSERT(a_no_spurious, accept && !is_text |=> !out_valid, "result without a text word")
  // Finish holds off input while walking
  `KSCU_ASSERT(a_finish_busy, accept && is_finish |=> in_stall, "input taken during finish")
  // Reset empties the result register
  `KSCU_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind keyword_substitution_cipher_unit kscu_checker u_kscu_checker (.*);
